// ===== hdl/aces_tonemap_gamma_quantize_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ACES_TONEMAP_GAMMA_QUANTIZE_MACROS_SVH
`define ACES_TONEMAP_GAMMA_QUANTIZE_MACROS_SVH

// Condition implies consequence in the next cycle.
`define ATGQ_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

// Condition implies consequence in the same cycle.
`define ATGQ_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Check that holds also during reset.
`define ATGQ_ASSERT_RST(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("reset check failed");

`endif

// ===== hdl/atgq_pkg.sv =====
package atgq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int CH_W      = 24;
  localparam int BYTE_W    = 8;
  localparam int IN_W      = INT_BITS + FRAC_BITS;
  localparam int WIDE_W    = 48;
  localparam int XW        = FRAC_BITS + 4;
  localparam int SQW       = 2 * XW;
  localparam int NW        = 2 * FRAC_BITS + 16;
  localparam int QW        = 18;
  localparam int TW        = 17;
  localparam int DIV_STEPS = QW - 1;
  localparam int SRCH_STEPS = BYTE_W;
  localparam int LANE_LAT  = 4 + DIV_STEPS + 1 + SRCH_STEPS;
  localparam int BIG_W     = 200;
  localparam int NTHR      = 1 << BYTE_W;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TW-1:0]     tone_t;
  typedef tone_t thr_arr_t [NTHR];

  function automatic logic [BIG_W-1:0] pow_n(input logic [BIG_W-1:0] b, input int n);
    logic [BIG_W-1:0] acc;
    acc = BIG_W'(1);
    for (int i = 0; i < n; i++) acc = acc * b;
    return acc;
  endfunction

  // Smallest Q0.16 tone value that rounds up to byte k under gamma 1/2.2.
  function automatic thr_arr_t build_thr();
    thr_arr_t res;
    logic [BIG_W-1:0] c510;
    logic [BIG_W-1:0] rhs;
    logic [TW-1:0] t;
    logic [TW-1:0] cand;
    c510 = pow_n(BIG_W'(510), 11);
    res[0] = '0;
    for (int k = 1; k < NTHR; k++) begin
      rhs = pow_n(BIG_W'(2 * k - 1), 11) << 80;
      t = '0;
      for (int b = TW - 1; b >= 0; b--) begin
        cand = t | (TW'(1) << b);
        if (pow_n(BIG_W'(cand), 5) * c510 < rhs) t = cand;
      end
      res[k] = t + TW'(1);
    end
    return res;
  endfunction

  localparam thr_arr_t THR = build_thr();

endpackage

// ===== hdl/atgq_lane.sv =====
module atgq_lane (
  input  logic           clk,
  input  logic           en,
  input  atgq_pkg::chan_t x,
  output atgq_pkg::byte_t y
);
  import atgq_pkg::*;

  localparam logic [WIDE_W-1:0] IN_MASK = (WIDE_W'(1) << IN_W) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] EIGHT   = WIDE_W'(8) << FRAC_BITS;

  logic [WIDE_W-1:0] xm;
  logic [XW-1:0]     xs_next;
  logic [XW-1:0]     xs;
  logic [XW-1:0]     xs2;
  logic [SQW-1:0]    sq;
  logic [NW-1:0]     num_next, den_next, num, den;
  logic [NW-1:0]     rem [DIV_STEPS+1];
  logic [NW-1:0]     dv  [DIV_STEPS+1];
  logic [QW-1:0]     quo [DIV_STEPS+1];
  logic [QW:0]       rnd;
  tone_t             tone_next;
  tone_t             tt  [SRCH_STEPS+1];
  byte_t             bb  [SRCH_STEPS+1];

  always_comb begin
    xm = WIDE_W'(x) & IN_MASK;
    xs_next = (xm > EIGHT) ? EIGHT[XW-1:0] : xm[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs  <= xs_next;
      xs2 <= xs;
      sq  <= xs * xs;
    end
  end

  always_comb begin
    num_next = NW'(sq) * NW'(251) + ((NW'(xs2) * NW'(3)) << FRAC_BITS);
    den_next = NW'(sq) * NW'(243) + ((NW'(xs2) * NW'(59)) << FRAC_BITS)
             + (NW'(14) << (2 * FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_next;
      den <= den_next;
      dv[0]  <= den;
      quo[0] <= (num >= den) ? QW'(1) : QW'(0);
      rem[0] <= (num >= den) ? num - den : num;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [NW:0] rs;
    assign rs = {rem[i], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        if (rs >= {1'b0, dv[i]}) begin
          rem[i+1] <= NW'(rs - {1'b0, dv[i]});
          quo[i+1] <= {quo[i][QW-2:0], 1'b1};
        end else begin
          rem[i+1] <= rs[NW-1:0];
          quo[i+1] <= {quo[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    rnd = ({1'b0, quo[DIV_STEPS]} + (QW+1)'(1)) >> 1;
    tone_next = (rnd > (QW+1)'(65536)) ? TW'(65536) : rnd[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tt[0] <= tone_next;
      bb[0] <= '0;
    end
  end

  for (genvar i = 0; i < SRCH_STEPS; i++) begin : g_srch
    byte_t cand;
    assign cand = bb[i] | (byte_t'(1) << (SRCH_STEPS - 1 - i));
    always_ff @(posedge clk) begin
      if (en) begin
        tt[i+1] <= tt[i];
        bb[i+1] <= (tt[i] >= THR[cand]) ? cand : bb[i];
      end
    end
  end

  assign y = bb[SRCH_STEPS];

endmodule

// ===== hdl/aces_tonemap_gamma_quantize.sv =====
// ACES filmic tone map, gamma 1/2.2 and byte quantization, one RGB pixel per
// transaction.
// Input channel: in_valid/in_ready with red_in, green_in, blue_in, unsigned
// fixed point with FRAC_BITS fraction bits. Output channel: out_valid/out_ready
// with red_out, green_out, blue_out bytes.
// Three identical lanes, one per color, run in lockstep; each is a pipeline of
// curve products, a restoring divider with one quotient bit per stage, a
// rounding stage and a binary search over the gamma threshold table, one bit
// per stage. A final output register merges the three bytes.
// Throughput: one pixel per cycle while the receiver is not stalling. A pixel
// passes through 30 lane stages, the first loaded at the accepting edge, then
// the output register, before out_valid rises.
// Reset clears all valid flags; no clearing pass is needed.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; it resumes as soon as out_ready returns.
`include "aces_tonemap_gamma_quantize_macros.svh"

module aces_tonemap_gamma_quantize (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  atgq_pkg::chan_t red_in,
  input  atgq_pkg::chan_t green_in,
  input  atgq_pkg::chan_t blue_in,
  output logic            out_valid,
  input  logic            out_ready,
  output atgq_pkg::byte_t red_out,
  output atgq_pkg::byte_t green_out,
  output atgq_pkg::byte_t blue_out
);
  import atgq_pkg::*;

  logic                en;
  logic [LANE_LAT-1:0] vld;
  byte_t               r_b, g_b, b_b;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  atgq_lane u_red   (.clk(clk), .en(en), .x(red_in),   .y(r_b));
  atgq_lane u_green (.clk(clk), .en(en), .x(green_in), .y(g_b));
  atgq_lane u_blue  (.clk(clk), .en(en), .x(blue_in),  .y(b_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[LANE_LAT-2:0], in_valid};
      out_valid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= r_b;
      green_out <= g_b;
      blue_out  <= b_b;
    end
  end

  `ATGQ_ASSERT_NEXT(a_enter, in_valid && in_ready, vld[0])
  `ATGQ_ASSERT_NEXT(a_drain, en && vld[LANE_LAT-1], out_valid)
  `ATGQ_ASSERT_NEXT(a_hold, !en, $stable(vld))
  `ATGQ_ASSERT_RST(a_reset, rst, !out_valid && vld == '0)

endmodule
